/* rtl/core/differential_drive_odometry_defines.svh */
// Assertion macros shared by the odometry RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define DDO_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DDO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* rtl/core/ddo_pkg.sv */
// Package for the odometry block: constants, sequencer states, tables.
// Depends on nothing.
package ddo_pkg;
   localparam int CordicSteps = 24;
   localparam int StepW = $clog2(CordicSteps + 1);
   localparam logic [31:0] CordicGain = 32'h9B74EDA8;
   localparam logic [31:0] RadToBam = 32'd683565276;
   localparam logic [19:0] UsPerS = 20'd1000000;
   localparam logic [0:0] CsrMpp = 1'b0;
   localparam logic [0:0] CsrIws = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DL, ST_DR, ST_D, ST_TH, ST_BAM, ST_GAIN, ST_CORDIC,
      ST_POS, ST_VLIN, ST_DIV, ST_VANG, ST_DIV2, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } div_ctl_type;

   function automatic logic [31:0] atan_bam(input logic [4:0] i);
      logic [31:0] t;
      unique case (i)
         5'd0: t = 32'h20000000; 5'd1: t = 32'h12E4051E; 5'd2: t = 32'h09FB385B;
         5'd3: t = 32'h051111D4; 5'd4: t = 32'h028B0D43; 5'd5: t = 32'h0145D7E1;
         5'd6: t = 32'h00A2F61E; 5'd7: t = 32'h00517C55; 5'd8: t = 32'h0028BE53;
         5'd9: t = 32'h00145F2F; 5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
         5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3; 5'd14: t = 32'h0000A2F9;
         5'd15: t = 32'h0000517C; 5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
         5'd18: t = 32'h00000A2F; 5'd19: t = 32'h00000517; 5'd20: t = 32'h0000028B;
         5'd21: t = 32'h00000145; 5'd22: t = 32'h000000A2; 5'd23: t = 32'h00000051;
         5'd24: t = 32'h00000028; 5'd25: t = 32'h00000014; 5'd26: t = 32'h0000000A;
         5'd27: t = 32'h00000005; 5'd28: t = 32'h00000002; 5'd29: t = 32'h00000001;
         default: t = 32'h0;
      endcase
      return t;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction
endpackage

/* rtl/core/ddo_if.sv */
// Valid/ready channel interfaces for the odometry block.
// Depends on nothing.
interface ddo_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] left_count;
   logic signed [31:0] right_count;
   logic [23:0] elapsed_us;
   modport source (output valid, left_count, right_count, elapsed_us, input ready);
   modport sink (input valid, left_count, right_count, elapsed_us, output ready);
endinterface

interface ddo_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic [31:0] heading;
   logic signed [31:0] linear_vel;
   logic signed [31:0] angular_vel;
   logic time_error;
   modport source (output valid, pos_x, pos_y, heading, linear_vel, angular_vel,
      time_error, input ready);
   modport sink (input valid, pos_x, pos_y, heading, linear_vel, angular_vel,
      time_error, output ready);
endinterface

interface ddo_csr_if;
   logic valid;
   logic ready;
   logic [0:0] index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/ddo_div.sv */
// Restoring divider: signed 52 bit dividend by unsigned 24 bit divisor, one bit per cycle.
// Depends on ddo_pkg and the assertion macros.
`include "differential_drive_odometry_defines.svh"
module ddo_div import ddo_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  div_ctl_type ctl,
   input  logic signed [51:0] dividend,
   input  logic [23:0] divisor,
   output logic done,
   output logic signed [31:0] quotient
);
   logic [51:0] q_ff, q_in;
   logic [24:0] r_ff, r_in;
   logic [5:0] n_ff, n_in;
   logic neg_ff, neg_in;
   logic run_ff, run_in;
   logic [24:0] trial;
   logic [52:0] qs;

   always_comb begin
      q_in = q_ff; r_in = r_ff; n_in = n_ff; neg_in = neg_ff; run_in = run_ff;
      trial = {r_ff[23:0], q_ff[51]} - {1'b0, divisor};
      if (ctl.start) begin
         neg_in = dividend[51];
         q_in = dividend[51] ? 52'(-dividend) : 52'(dividend);
         r_in = '0; n_in = 6'd52; run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[24]) begin
            r_in = trial; q_in = {q_ff[50:0], 1'b1};
         end else begin
            r_in = {r_ff[23:0], q_ff[51]}; q_in = {q_ff[50:0], 1'b0};
         end
         n_in = n_ff - 6'd1;
         if (n_ff == 6'd1) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; neg_ff <= neg_in;
      if (reset) begin
         run_ff <= 1'b0; n_ff <= '0;
      end else begin
         run_ff <= run_in; n_ff <= n_in;
      end
   end

   assign done = !run_ff && !ctl.start;
   assign qs = neg_ff ? -{1'b0, q_ff} : {1'b0, q_ff};
   assign quotient = sat32(64'(signed'(qs)));

   `DDO_ASSERT_NEXT(a_start_runs, clock, reset, ctl.start, run_ff)
   `DDO_ASSERT_IMPL(a_count_live, clock, reset, run_ff, n_ff != 6'd0)
   `DDO_ASSERT_IMPL(a_no_restart, clock, reset, run_ff, !ctl.start)
endmodule

/* rtl/core/differential_drive_odometry.sv */
// Top level of the differential drive odometry block: sequencer, CORDIC, pose state.
// Depends on ddo_pkg, ddo_if, ddo_div and the assertion macros.
//
// channel  dir  word
// req      in   left_count, right_count, elapsed_us
// rsp      out  pos_x, pos_y, heading, linear_vel, angular_vel, time_error
// csr      in   index, data (register write)
//
// When the elapsed time is zero the divisions are skipped and both velocities are zero.
// Six setup steps, 24 CORDIC steps and a pose update step come first.
// Two divisions then follow, each a restoring loop that yields one bit per cycle.
// Reset clears pose, stored counts and registers to their defaults.
// The block takes no new word until the result has been taken.
`include "differential_drive_odometry_defines.svh"
module differential_drive_odometry import ddo_pkg::*; (
   input logic clock,
   input logic reset,
   ddo_req_if.sink req,
   ddo_rsp_if.source rsp,
   ddo_csr_if.sink csr
);
   state_type state_ff, state_in;
   logic [31:0] mpp_ff;
   logic [23:0] iws_ff;
   logic [31:0] pl_ff, pl_in, pr_ff, pr_in;
   logic signed [31:0] bx_ff, bx_in, by_ff, by_in;
   logic [31:0] bh_ff, bh_in;
   logic signed [31:0] dl_ff, dl_in, dr_ff, dr_in, d_ff, d_in, th_ff, th_in;
   logic [31:0] bam_ff, bam_in;
   logic signed [31:0] lc_ff, lc_in, rc_ff, rc_in;
   logic [23:0] us_ff, us_in;
   logic signed [49:0] x_ff, x_in, y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   logic [StepW-1:0] i_ff, i_in;
   logic signed [31:0] lv_ff, lv_in, av_ff, av_in;
   logic signed [63:0] prod;
   logic signed [32:0] ma;
   logic signed [32:0] mb;
   logic [31:0] dlc, drc;
   logic signed [49:0] xs, ys;
   logic [31:0] phi;
   logic [31:0] phi_f;
   logic signed [51:0] dvd;
   logic div_done;
   logic signed [31:0] div_q;
   div_ctl_type dctl;

   assign req.ready = state_ff == ST_IDLE;
   assign csr.ready = 1'b1;
   assign rsp.valid = state_ff == ST_OUT;
   assign rsp.pos_x = bx_ff;
   assign rsp.pos_y = by_ff;
   assign rsp.heading = bh_ff;
   assign rsp.linear_vel = lv_ff;
   assign rsp.angular_vel = av_ff;
   assign rsp.time_error = us_ff == 24'd0;

   // One shared multiplier; operands are chosen by the sequencer state.
   always_comb begin
      dlc = lc_ff - pl_ff;
      drc = rc_ff - pr_ff;
      priority case (state_ff)
         ST_DL: begin ma = {dlc[31], dlc}; mb = {1'b0, mpp_ff}; end
         ST_DR: begin ma = {drc[31], drc}; mb = {1'b0, mpp_ff}; end
         ST_TH: begin ma = {dr_ff[31], dr_ff} - {dl_ff[31], dl_ff}; mb = {9'd0, iws_ff}; end
         ST_BAM: begin ma = {th_ff[31], th_ff}; mb = {1'b0, RadToBam}; end
         ST_GAIN: begin ma = {d_ff[31], d_ff}; mb = {1'b0, CordicGain}; end
         ST_VLIN: begin ma = {d_ff[31], d_ff}; mb = {13'd0, UsPerS}; end
         ST_VANG: begin ma = {th_ff[31], th_ff}; mb = {13'd0, UsPerS}; end
         default: begin ma = '0; mb = '0; end
      endcase
      prod = 64'(ma) * 64'(mb);
   end

   always_comb begin
      state_in = state_ff;
      pl_in = pl_ff; pr_in = pr_ff; bx_in = bx_ff; by_in = by_ff; bh_in = bh_ff;
      dl_in = dl_ff; dr_in = dr_ff; d_in = d_ff; th_in = th_ff; bam_in = bam_ff;
      lc_in = lc_ff; rc_in = rc_ff; us_in = us_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff;
      lv_in = lv_ff; av_in = av_ff;
      dctl = '0; dvd = prod[51:0];
      xs = x_ff >>> i_ff; ys = y_ff >>> i_ff;
      phi = bh_ff - bam_ff;
      phi_f = phi - 32'h80000000;
      unique case (state_ff)
         ST_IDLE: if (req.valid) begin
            lc_in = req.left_count; rc_in = req.right_count; us_in = req.elapsed_us;
            state_in = ST_DL;
         end
         ST_DL: begin dl_in = sat32((prod + 64'sd32768) >>> 16); state_in = ST_DR; end
         ST_DR: begin
            dr_in = sat32((prod + 64'sd32768) >>> 16);
            pl_in = lc_ff; pr_in = rc_ff; state_in = ST_D;
         end
         ST_D: begin
            d_in = 32'((({dl_ff[31], dl_ff} + {dr_ff[31], dr_ff}) + 33'sd1) >>> 1);
            state_in = ST_TH;
         end
         ST_TH: begin th_in = sat32((prod + 64'sd32768) >>> 16); state_in = ST_BAM; end
         ST_BAM: begin bam_in = prod[47:16]; state_in = ST_GAIN; end
         ST_GAIN: begin
            x_in = 50'((prod + 64'sd32768) >>> 16);
            y_in = '0; i_in = '0;
            if (((phi + 32'h40000000) & 32'h80000000) != 32'd0) begin
               x_in = -50'((prod + 64'sd32768) >>> 16);
               z_in = {phi_f[31], phi_f};
            end else begin
               z_in = {phi[31], phi};
            end
            state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            if (!z_ff[32]) begin
               x_in = x_ff - ys; y_in = y_ff + xs;
               z_in = z_ff - {1'b0, atan_bam(5'(i_ff))};
            end else begin
               x_in = x_ff + ys; y_in = y_ff - xs;
               z_in = z_ff + {1'b0, atan_bam(5'(i_ff))};
            end
            i_in = i_ff + StepW'(1);
            if (i_ff == StepW'(CordicSteps - 1)) state_in = ST_POS;
         end
         ST_POS: begin
            bx_in = sat32(64'(bx_ff) + 64'((x_ff + 50'sd32768) >>> 16));
            by_in = sat32(64'(by_ff) + 64'((y_ff + 50'sd32768) >>> 16));
            bh_in = bh_ff + bam_ff;
            state_in = ST_VLIN;
         end
         ST_VLIN: begin
            if (us_ff == 24'd0) begin
               lv_in = '0; av_in = '0; state_in = ST_OUT;
            end else begin
               dctl.start = 1'b1; state_in = ST_DIV;
            end
         end
         ST_DIV: if (div_done) begin lv_in = div_q; state_in = ST_VANG; end
         ST_VANG: begin dctl.start = 1'b1; state_in = ST_DIV2; end
         ST_DIV2: if (div_done) begin av_in = div_q; state_in = ST_OUT; end
         ST_OUT: if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      dctl.busy = state_ff == ST_DIV || state_ff == ST_DIV2;
   end

   ddo_div u_div (
      .clock(clock), .reset(reset), .ctl(dctl), .dividend(dvd),
      .divisor(us_ff), .done(div_done), .quotient(div_q)
   );

   always_ff @(posedge clock) begin
      dl_ff <= dl_in; dr_ff <= dr_in; d_ff <= d_in; th_ff <= th_in; bam_ff <= bam_in;
      lc_ff <= lc_in; rc_ff <= rc_in; us_ff <= us_in;
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; i_ff <= i_in;
      lv_ff <= lv_in; av_ff <= av_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         mpp_ff <= 32'd890430; iws_ff <= 24'd436907;
         pl_ff <= '0; pr_ff <= '0; bx_ff <= '0; by_ff <= '0; bh_ff <= '0;
      end else begin
         state_ff <= state_in;
         pl_ff <= pl_in; pr_ff <= pr_in; bx_ff <= bx_in; by_ff <= by_in; bh_ff <= bh_in;
         if (csr.valid && csr.index == CsrMpp) mpp_ff <= csr.data;
         if (csr.valid && csr.index == CsrIws) iws_ff <= csr.data[23:0];
      end
   end

   `DDO_ASSERT_IMPL(a_ready_idle, clock, reset, req.ready, !rsp.valid)
   `DDO_ASSERT_NEXT(a_accept_runs, clock, reset, req.valid && req.ready, state_ff == ST_DL)
   `DDO_ASSERT_IMPL(a_div_wait, clock, reset, dctl.busy, !req.ready && !rsp.valid)
endmodule
